>>> rtl/tta_pkg.sv
// Shared constants for the tiled texture untile address generator.
// Register indexes, field widths and limits; no dependencies.
`default_nettype none

package tta_pkg;

  localparam int unsigned MAX_DIM_DEFAULT = 8192;

  localparam int unsigned COORD_W  = 13;
  localparam int unsigned OFFSET_W = 30;
  localparam int unsigned LOG2_W   = 3;
  localparam int unsigned TILES_W  = 9;
  localparam int unsigned PITCH_W  = 18;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 18;

  // Largest bytes-per-texel log2 (16-byte blocks).
  localparam logic [LOG2_W-1:0] MAX_LOG2 = 3'd4;
  localparam logic [LOG2_W-1:0] RESET_LOG2 = 3'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEXEL_BYTES_LOG2 = 2'd0,
    REG_TILES_PER_ROW    = 2'd1,
    REG_DST_ROW_PITCH    = 2'd2
  } cfg_reg_t;

endpackage

`default_nettype wire

>>> rtl/tiled_texture_untile_address_core.sv
// Untile address generator: tiled source offset and linear destination offset.
// Depends on tta_pkg.
//
//   channel   handshake               payload
//   -------   ---------------------   -----------------------------------------
//   request   start / busy            src_x, src_y, dst_x, dst_y
//   result    done (one-cycle strobe) tiled_offset, linear_offset
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One request per cycle while rst is low; each result is registered in the multiply stage,
// the offset-assembly stage and the output register, in that order, after its request is taken.
// rst is synchronous; busy is held high and cfg_ready low while it is high and
// the pipeline valid bits are cleared. The receiver cannot stall, so there is
// no backpressure: busy is low whenever rst is low.
`default_nettype none

module tiled_texture_untile_address_core
  import tta_pkg::*;
#(
  parameter int unsigned MAX_DIM = MAX_DIM_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [COORD_W-1:0]    src_x,
  input  wire logic [COORD_W-1:0]    src_y,
  input  wire logic [COORD_W-1:0]    dst_x,
  input  wire logic [COORD_W-1:0]    dst_y,
  output logic                       done,
  output logic [OFFSET_W-1:0]        tiled_offset,
  output logic [OFFSET_W-1:0]        linear_offset,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned MAX_TILES = MAX_DIM / 32;
  localparam int unsigned TW = $clog2(MAX_TILES + 1);
  localparam int unsigned PW = (COORD_W - 5) + TW;   // macro row product
  localparam int unsigned MW = PW + 1;               // macro tile index
  localparam int unsigned LW = PITCH_W + COORD_W;    // pitch * row
  localparam int unsigned OW = 32;                   // offset work width

  // Configuration, stored already clamped.
  logic [LOG2_W-1:0]  texel_bytes_log2;
  logic [TW-1:0]      tiles_per_row;
  logic [PITCH_W-1:0] dst_row_pitch;

  logic accept;
  logic cfg_write;

  assign busy      = rst;
  assign cfg_ready = !rst;
  assign accept    = start && !busy;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      texel_bytes_log2 <= RESET_LOG2;
      tiles_per_row    <= TW'(1);
      dst_row_pitch    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TEXEL_BYTES_LOG2: begin
          if (cfg_data[LOG2_W-1:0] > MAX_LOG2) begin
            texel_bytes_log2 <= MAX_LOG2;
          end else begin
            texel_bytes_log2 <= cfg_data[LOG2_W-1:0];
          end
        end
        REG_TILES_PER_ROW: begin
          if (cfg_data[TILES_W-1:0] > TILES_W'(MAX_TILES)) begin
            tiles_per_row <= TW'(MAX_TILES);
          end else begin
            tiles_per_row <= TW'(cfg_data[TILES_W-1:0]);
          end
        end
        REG_DST_ROW_PITCH: begin
          dst_row_pitch <= cfg_data[PITCH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Stage 1: the two multiplies.
  logic               v1;
  logic [COORD_W-1:0] x1;
  logic [4:0]         y1;
  logic [COORD_W-1:0] dx1;
  logic [PW-1:0]      macro_row;
  logic [LW-1:0]      lin_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    x1        <= src_x;
    y1        <= src_y[4:0];
    dx1       <= dst_x;
    macro_row <= PW'(src_y[COORD_W-1:5] * tiles_per_row);
    lin_prod  <= LW'(dst_row_pitch * dst_y);
  end

  // Stage 2: macro index, byte offset inside the tile row, linear sum.
  logic [MW-1:0]       macro;
  logic [5:0]          micro_texel;
  logic [9:0]          micro;
  logic [LOG2_W:0]     macro_shift;
  logic [LOG2_W:0]     row8_shift;
  logic [OW-1:0]       off_next;
  logic [OW-1:0]       lin_next;

  always_comb begin
    macro       = MW'(x1[COORD_W-1:5]) + MW'(macro_row);
    micro_texel = 6'({3'b000, x1[2:0]}) + 6'({y1[2:1], 3'b000});
    micro       = 10'(micro_texel) << texel_bytes_log2;
    macro_shift = {1'b0, texel_bytes_log2} + (LOG2_W+1)'(7);
    row8_shift  = {1'b0, texel_bytes_log2} + (LOG2_W+1)'(3);
    off_next    = (OW'(macro) << macro_shift)
                + OW'({micro[9:4], 5'b00000})
                + OW'(micro[3:0])
                + (OW'({y1[3], 3'b000}) << row8_shift)
                + OW'({y1[0], 4'b0000});
    lin_next    = OW'(lin_prod) + (OW'(dx1) << texel_bytes_log2);
  end

  logic          v2;
  logic [OW-1:0] off2;
  logic [1:0]    ybits2;   // src_y bits 4:3
  logic [1:0]    xbits2;   // src_x bits 4:3
  logic [OFFSET_W-1:0] lin2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    off2   <= off_next;
    ybits2 <= y1[4:3];
    xbits2 <= x1[4:3];
    lin2   <= lin_next[OFFSET_W-1:0];
  end

  // Stage 3: bank/pipe swizzle into the final tiled offset.
  logic [1:0]          bank_sel;
  logic [OFFSET_W-1:0] tiled_next;

  always_comb begin
    bank_sel   = {ybits2[0], 1'b0} + xbits2;
    tiled_next = OFFSET_W'({off2[OW-1:9], 9'd0} << 3)
               + OFFSET_W'({off2[8:6], 6'd0} << 2)
               + OFFSET_W'(off2[5:0])
               + OFFSET_W'({ybits2[1], 11'd0})
               + OFFSET_W'({bank_sel, 6'd0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    tiled_offset  <= tiled_next;
    linear_offset <= lin2;
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 done)
    else $error("accepted request did not produce a result three cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(v1, 2))
    else $error("result strobe without a matching request");

  a_log2_clamped: assert property (@(posedge clk) disable iff (rst)
    texel_bytes_log2 <= MAX_LOG2)
    else $error("texel size log2 above limit");

  a_tiles_clamped: assert property (@(posedge clk) disable iff (rst)
    tiles_per_row <= TW'(MAX_TILES))
    else $error("tiles per row above limit");
`endif

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 100ps
// Testbench for tiled_texture_untile_address_core: directed and random texel requests,
// checked against an in-bench offset predictor. Depends on tta_pkg and the core RTL.

module tb;
  import tta_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned MAX_TILES = MAX_DIM_DEFAULT / 32;
  localparam int unsigned PIPE_CYCLES = 3;
  localparam int unsigned REQ_W = 4 * COORD_W;

  typedef struct packed {
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
  } texel_req_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] tiled;
    logic [OFFSET_W-1:0] linear;
  } offsets_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [COORD_W-1:0]    src_x = '0;
  logic [COORD_W-1:0]    src_y = '0;
  logic [COORD_W-1:0]    dst_x = '0;
  logic [COORD_W-1:0]    dst_y = '0;
  logic                  done;
  logic [OFFSET_W-1:0]   tiled_offset;
  logic [OFFSET_W-1:0]   linear_offset;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow copy of the register file
  logic [LOG2_W-1:0]  cfg_log2 = RESET_LOG2;
  logic [TILES_W-1:0] cfg_tiles = 9'd1;
  logic [PITCH_W-1:0] cfg_pitch = '0;

  texel_req_t reqs_pending[$];
  offsets_t   offsets_due[$];
  int         gap_pct = 12;
  int         mismatches = 0;

  tiled_texture_untile_address_core u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .src_x(src_x),
    .src_y(src_y),
    .dst_x(dst_x),
    .dst_y(dst_y),
    .done(done),
    .tiled_offset(tiled_offset),
    .linear_offset(linear_offset),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #200000;
    $display("[tiled_texture_untile_address_core] ERROR");
    $finish;
  end

  function automatic offsets_t untile_offsets(texel_req_t r);
    logic [63:0] x, y, b, tiles, macro_idx, micro, off, bank, tiled, linear;
    offsets_t o;
    x = 64'(r.sx);
    y = 64'(r.sy);
    b = (cfg_log2 > MAX_LOG2) ? 64'(MAX_LOG2) : 64'(cfg_log2);
    tiles = (cfg_tiles > MAX_TILES) ? 64'(MAX_TILES) : 64'(cfg_tiles);
    macro_idx = (x >> 5) + (y >> 5) * tiles;
    micro = ((x & 7) + ((y & 6) << 2)) << b;
    off = (macro_idx << (b + 7)) + ((micro & ~64'd15) << 1) + (micro & 15)
        + ((y & 8) << (b + 3)) + ((y & 1) << 4);
    // bank/channel swizzle inside the macro tile
    bank = ((((y & 8) >> 2) + (x >> 3)) & 3) << 6;
    tiled = ((off & ~64'd511) << 3) + ((off & 448) << 2) + (off & 63)
          + ((y & 16) << 7) + bank;
    linear = 64'(cfg_pitch) * 64'(r.dy) + (64'(r.dx) << b);
    o.tiled = tiled[OFFSET_W-1:0];
    o.linear = linear[OFFSET_W-1:0];
    return o;
  endfunction

  always @(posedge clk) begin : drive_requests
    texel_req_t req;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        req = '{src_x, src_y, dst_x, dst_y};
        offsets_due.push_back(untile_offsets(req));
      end
      if (!start || !busy) begin
        if (reqs_pending.size() != 0 && $urandom_range(99) >= gap_pct) begin
          req = reqs_pending.pop_front();
          src_x <= req.sx;
          src_y <= req.sy;
          dst_x <= req.dx;
          dst_y <= req.dy;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    offsets_t want;
    if (!rst && done) begin
      if (offsets_due.size() == 0) begin
        $display("%0t unexpected result: tiled_offset %h linear_offset %h",
                 $time, tiled_offset, linear_offset);
        mismatches++;
      end else begin
        want = offsets_due.pop_front();
        if (tiled_offset !== want.tiled) begin
          $display("%0t tiled_offset expected %h actual %h", $time, want.tiled, tiled_offset);
          mismatches++;
        end
        if (linear_offset !== want.linear) begin
          $display("%0t linear_offset expected %h actual %h",
                   $time, want.linear, linear_offset);
          mismatches++;
        end
      end
    end
  end

  task automatic push_req(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                          input logic [COORD_W-1:0] dx, input logic [COORD_W-1:0] dy);
    reqs_pending.push_back('{sx, sy, dx, dy});
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TEXEL_BYTES_LOG2: cfg_log2 = data[LOG2_W-1:0];
      REG_TILES_PER_ROW:    cfg_tiles = data[TILES_W-1:0];
      REG_DST_ROW_PITCH:    cfg_pitch = data[PITCH_W-1:0];
      default: ;
    endcase
  endtask

  // sampled on the falling edge so the queues are settled
  task automatic wait_idle();
    do @(negedge clk); while (reqs_pending.size() != 0 || start || offsets_due.size() != 0);
    repeat (PIPE_CYCLES + 1) @(posedge clk);
  endtask

  initial begin : stimulus
    texel_req_t         base;
    int                 run_left;
    int                 step;
    logic [CFG_DATA_W-1:0] junk;
    logic [LOG2_W-1:0]  lg;
    logic [TILES_W-1:0] tl;
    logic [PITCH_W-1:0] pt;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings
    @(negedge clk);
    push_req(0, 0, 0, 0);
    push_req(8191, 8191, 8191, 8191);
    push_req(31, 31, 31, 31);
    push_req(32, 33, 1, 1);
    push_req(7, 6, 5, 0);
    push_req(8, 9, 0, 8191);
    push_req(24, 24, 4096, 4096);
    wait_idle();

    // largest legal log2 and tile count settings
    set_reg(REG_TEXEL_BYTES_LOG2, 18'd4);
    set_reg(REG_TILES_PER_ROW, 18'd256);
    set_reg(REG_DST_ROW_PITCH, 18'd131072);
    @(negedge clk);
    push_req(8191, 8191, 8191, 8191);
    push_req(5000, 4000, 100, 7000);
    push_req(8160, 8160, 8191, 0);
    wait_idle();

    // oversize log2 and tile count saturate; pitch at full field width wraps
    set_reg(REG_TEXEL_BYTES_LOG2, 18'd7);
    set_reg(REG_TILES_PER_ROW, 18'd511);
    set_reg(REG_DST_ROW_PITCH, 18'h3FFFF);
    @(negedge clk);
    push_req(8191, 8191, 8191, 8191);
    push_req(4095, 4096, 4096, 4095);
    push_req(0, 8191, 0, 8191);
    push_req(8191, 0, 8191, 0);
    wait_idle();

    // zero tiles per row; write to the unused index must not land anywhere
    set_reg(REG_TEXEL_BYTES_LOG2, 18'd0);
    set_reg(REG_TILES_PER_ROW, 18'd0);
    set_reg(REG_DST_ROW_PITCH, 18'd0);
    set_reg(REG_UNUSED, 18'h3FFFF);
    @(negedge clk);
    push_req(8191, 8191, 8191, 8191);
    push_req(100, 3000, 77, 8000);
    push_req(15, 17, 2, 2);
    push_req(33, 64, 8191, 1);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      junk = (ph % 2) ? CFG_DATA_W'($urandom) : '0;  // bits above the register width
      lg = ($urandom_range(99) < 15) ? LOG2_W'($urandom_range(7, 5))
                                     : LOG2_W'($urandom_range(4));
      case ($urandom_range(9))
        0:       tl = '0;
        1, 2:    tl = TILES_W'($urandom_range(511, 257));
        default: tl = TILES_W'($urandom_range(256, 1));
      endcase
      pt = ($urandom_range(99) < 20) ? PITCH_W'($urandom_range(4096))
                                     : PITCH_W'($urandom_range(262143));
      set_reg(REG_TEXEL_BYTES_LOG2, (junk & ~18'h7) | CFG_DATA_W'(lg));
      set_reg(REG_TILES_PER_ROW, (junk & ~18'h1FF) | CFG_DATA_W'(tl));
      set_reg(REG_DST_ROW_PITCH, CFG_DATA_W'(pt));
      if (ph % 3 == 1) set_reg(REG_UNUSED, CFG_DATA_W'($urandom));
      gap_pct = (ph == 4) ? 0 : 12;
      @(negedge clk);
      run_left = 0;
      step = 0;
      for (int n = 0; n < 128; n++) begin
        // mix row scans (consecutive texels) with scattered texels
        if (run_left == 0 && $urandom_range(99) < 30) begin
          base = REQ_W'({$urandom, $urandom});
          run_left = $urandom_range(16, 4);
          step = 0;
        end
        if (run_left > 0) begin
          push_req(COORD_W'(base.sx + step), base.sy, COORD_W'(base.dx + step), base.dy);
          step++;
          run_left--;
        end else begin
          push_req(COORD_W'($urandom), COORD_W'($urandom),
                   COORD_W'($urandom), COORD_W'($urandom));
        end
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("[tiled_texture_untile_address_core] OK");
    end else begin
      $display("[tiled_texture_untile_address_core] ERROR");
    end
    $finish;
  end

endmodule
